// File: rtl/ktbl_pkg.sv
`timescale 1ns / 1ps
// ktbl_pkg: widths, register indexes, reset values and shared types of the
// keyed token bucket limiter. No dependencies.
package ktbl_pkg;

    localparam int IDX_W      = 8;
    localparam int TOKEN_W    = 16;
    localparam int INTERVAL_W = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_REFILL_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_CAPACITY = 2'd1;

    localparam logic [INTERVAL_W-1:0] RST_REFILL_INTERVAL = 32'd1000000;
    localparam logic [TOKEN_W-1:0]    RST_BUCKET_CAPACITY = 16'd10;

    // divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: rtl/ktbl_req_if.sv
`timescale 1ns / 1ps
// ktbl_req_if: request channel (bucket index and time stamp) with valid/ready.
// Depends on ktbl_pkg.
interface ktbl_req_if #(
    parameter int TIME_WIDTH = 48
);
    logic                        valid;
    logic                        ready;
    logic [ktbl_pkg::IDX_W-1:0]  bucket_index;
    logic [TIME_WIDTH-1:0]       now_time;

    modport source (output valid, output bucket_index, output now_time, input ready);
    modport sink   (input valid, input bucket_index, input now_time, output ready);
endinterface

// File: rtl/ktbl_rsp_if.sv
`timescale 1ns / 1ps
// ktbl_rsp_if: response channel (grant flag and remaining tokens) with valid/ready.
// Depends on ktbl_pkg.
interface ktbl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          granted;
    logic [ktbl_pkg::TOKEN_W-1:0]  tokens_left;

    modport source (output valid, output granted, output tokens_left, input ready);
    modport sink   (input valid, input granted, input tokens_left, output ready);
endinterface

// File: rtl/keyed_token_bucket_limiter.sv
`timescale 1ns / 1ps
// keyed_token_bucket_limiter: per-bucket token bucket with a state memory and
// a serial divider. Depends on ktbl_pkg, ktbl_req_if, ktbl_rsp_if, ktbl_div.
//
//   channel | dir | handshake          | contents
//   --------+-----+--------------------+----------------------------------------
//   req     | in  | valid/ready        | bucket_index, now_time
//   rsp     | out | valid/ready        | granted, tokens_left
//   cfg     | in  | cfg_we, no wait    | cfg_index, cfg_data (interval, capacity)
//
// One request at a time. A request to a live bucket goes through the read, divide
// and update steps from accept to response; the bit-serial divider computes
// elapsed time / refill interval. A first request to a bucket skips the divider
// and goes from the read step straight to the update step.
// After reset a clearing pass writes every memory entry with req.ready low;
// configuration writes are taken throughout.
// A response waiting in the output register does not block the next accept;
// only the final update stalls until that register is free.
module keyed_token_bucket_limiter #(
    parameter int NUM_BUCKETS = 256,
    parameter int TIME_WIDTH  = 48
) (
    input  logic                               clk,
    input  logic                               rst_n,
    ktbl_req_if.sink                           req,
    ktbl_rsp_if.source                         rsp,
    input  logic                               cfg_we,
    input  logic [ktbl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ktbl_pkg::CFG_DATA_W-1:0]    cfg_data
);
    localparam int TW = ktbl_pkg::TOKEN_W;
    localparam int AW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int LUT_N = 1 << ktbl_pkg::IDX_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BUCKETS - 1);

    // one memory word per bucket
    typedef struct packed {
        logic                  valid;
        logic [TW-1:0]         tokens;
        logic [TIME_WIDTH-1:0] stamp;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_UPD
    } state_t;

    // ---------------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------------
    logic [ktbl_pkg::INTERVAL_W-1:0] interval_reg;
    logic [TW-1:0]                   cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= ktbl_pkg::RST_REFILL_INTERVAL;
            cap_reg      <= ktbl_pkg::RST_BUCKET_CAPACITY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ktbl_pkg::REG_REFILL_INTERVAL:
                    interval_reg <= cfg_data[ktbl_pkg::INTERVAL_W-1:0];
                ktbl_pkg::REG_BUCKET_CAPACITY:
                    cap_reg <= cfg_data[TW-1:0];
                default: ;  // unused indexes ignored
            endcase
        end
    end

    // zero settings behave as one
    logic [ktbl_pkg::INTERVAL_W-1:0] interval_eff;
    logic [TW-1:0]                   cap_eff;

    assign interval_eff = (interval_reg == '0) ? ktbl_pkg::INTERVAL_W'(1) : interval_reg;
    assign cap_eff      = (cap_reg == '0) ? TW'(1) : cap_reg;

    // ---------------------------------------------------------------------
    // index folding: constant lookup of bucket_index modulo NUM_BUCKETS
    // ---------------------------------------------------------------------
    logic [AW-1:0] idx_lut [LUT_N];

    for (genvar g = 0; g < LUT_N; g++)
    begin : g_lut
        assign idx_lut[g] = AW'(g % NUM_BUCKETS);
    end

    logic [AW-1:0] req_idx;
    assign req_idx = idx_lut[req.bucket_index];

    // ---------------------------------------------------------------------
    // sequencer registers
    // ---------------------------------------------------------------------
    state_t                state_reg;
    logic [AW-1:0]         clr_cnt_reg;
    logic [AW-1:0]         idx_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic                  rsp_valid_reg;
    logic                  rsp_granted_reg;
    logic [TW-1:0]         rsp_tokens_reg;

    logic req_fire;
    logic out_free;
    logic rsp_load;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign rsp_load  = (state_reg == ST_UPD) && out_free;

    // ---------------------------------------------------------------------
    // state memory: one write port, one registered read port
    // ---------------------------------------------------------------------
    entry_t        mem [NUM_BUCKETS];
    entry_t        rd_entry_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    entry_t        upd_entry;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (req_fire)
            rd_entry_reg <= mem[req_idx];
    end

    // ---------------------------------------------------------------------
    // elapsed time and division
    // ---------------------------------------------------------------------
    logic [TIME_WIDTH-1:0]   elapsed;
    logic [TIME_WIDTH-1:0]   gen;
    logic                    div_start;
    ktbl_pkg::div_status_t   div_st;

    // time going backward counts as nothing elapsed
    assign elapsed   = (now_reg >= rd_entry_reg.stamp) ? (now_reg - rd_entry_reg.stamp)
                                                       : '0;
    assign div_start = (state_reg == ST_READ) && rd_entry_reg.valid;

    ktbl_div #(
        .DW (TIME_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (elapsed),
        .divisor  (interval_eff),
        .quotient (gen),
        .status   (div_st)
    );

    // ---------------------------------------------------------------------
    // bucket update
    // ---------------------------------------------------------------------
    logic          gen_nz;
    logic          gen_ge_cap;
    logic [TW:0]   sum_wide;
    logic [TW-1:0] sum_clamped;
    logic          upd_grant;

    always_comb
    begin
        gen_nz      = |gen;
        gen_ge_cap  = (gen >= TIME_WIDTH'(cap_eff));
        sum_wide    = {1'b0, rd_entry_reg.tokens} + {1'b0, gen[TW-1:0]};
        // gen is below capacity whenever the low bits are used
        sum_clamped = (gen_ge_cap || (sum_wide > {1'b0, cap_eff})) ? cap_eff
                                                                   : sum_wide[TW-1:0];

        upd_entry.valid = 1'b1;
        if (!rd_entry_reg.valid)
        begin
            // first use: start full and take one
            upd_entry.tokens = cap_eff - TW'(1);
            upd_entry.stamp  = now_reg;
            upd_grant        = 1'b1;
        end
        else if (gen_nz)
        begin
            upd_entry.tokens = sum_clamped - TW'(1);
            upd_entry.stamp  = now_reg;
            upd_grant        = 1'b1;
        end
        else if (rd_entry_reg.tokens != '0)
        begin
            upd_entry.tokens = rd_entry_reg.tokens - TW'(1);
            upd_entry.stamp  = rd_entry_reg.stamp;
            upd_grant        = 1'b1;
        end
        else
        begin
            upd_entry.tokens = rd_entry_reg.tokens;
            upd_entry.stamp  = rd_entry_reg.stamp;
            upd_grant        = 1'b0;
        end
    end

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = (state_reg == ST_UPD) && out_free;
            mem_waddr = idx_reg;
            mem_wdata = upd_entry;
        end
    end

    // ---------------------------------------------------------------------
    // state machine and output register
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            idx_reg         <= '0;
            now_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_granted_reg <= 1'b0;
            rsp_tokens_reg  <= '0;
        end
        else
        begin
            // a new response may replace the one taken at this edge
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == LAST_IDX)
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (req_fire)
                    begin
                        idx_reg   <= req_idx;
                        now_reg   <= req.now_time;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= rd_entry_reg.valid ? ST_DIV : ST_UPD;
                end
                ST_DIV:
                begin
                    if (div_st.done)
                        state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    if (out_free)
                    begin
                        rsp_granted_reg <= upd_grant;
                        rsp_tokens_reg  <= upd_entry.tokens;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.granted     = rsp_granted_reg;
    assign rsp.tokens_left = rsp_tokens_reg;

`ifndef SYNTH
    // an accepted request is looked up in the following cycle
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == ST_READ))
        else $error("accepted request not followed by memory read");

    // a response appears only out of the update step
    a_rsp_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == ST_UPD))
        else $error("response raised outside the update step");

    // divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide step");

    // a new division never starts on top of a running one
    a_div_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_st.busy)
        else $error("divider started while busy");

    // a denial always leaves an empty bucket
    a_deny_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.granted) |-> (rsp.tokens_left == '0))
        else $error("denied request reports tokens left");
`endif

endmodule

// File: rtl/ktbl_div.sv
`timescale 1ns / 1ps
// ktbl_div: restoring serial divider, one quotient bit per cycle.
// Depends on ktbl_pkg.
module ktbl_div #(
    parameter int DW = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [DW-1:0]                     dividend,
    input  logic [ktbl_pkg::INTERVAL_W-1:0]   divisor,
    output logic [DW-1:0]                     quotient,
    output ktbl_pkg::div_status_t             status
);
    localparam int VW = ktbl_pkg::INTERVAL_W;
    localparam int CW = $clog2(DW + 1);
    localparam logic [CW-1:0] LAST_STEP = CW'(DW - 1);

    logic [VW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [VW:0]   shifted;
    logic [VW:0]   diff;
    logic          take;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DW-1]};
        diff     = shifted - {1'b0, dvs_reg};
        take     = (shifted >= {1'b0, dvs_reg});
        rem_next = take ? diff[VW-1:0] : shifted[VW-1:0];
        quo_next = {quo_reg[DW-2:0], take};
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
